### sv/baro_pkg.sv
// Shared types and constants for the barometer compensation and averaging block.
package baro_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_SENS      = 3'd0;
  localparam logic [2:0] REG_OFFSET    = 3'd1;
  localparam logic [2:0] REG_SENS_TC   = 3'd2;
  localparam logic [2:0] REG_OFFSET_TC = 3'd3;
  localparam logic [2:0] REG_TREF      = 3'd4;
  localparam logic [2:0] REG_TEMPSENS  = 3'd5;
  localparam logic [2:0] REG_AVG_COUNT = 3'd6;

  // Datapath operation codes issued by the controller.
  localparam logic [3:0] OP_NOP       = 4'd0;
  localparam logic [3:0] OP_LOAD      = 4'd1;
  localparam logic [3:0] OP_DT        = 4'd2;
  localparam logic [3:0] OP_MUL_TEMP  = 4'd3;
  localparam logic [3:0] OP_MUL_OFF   = 4'd4;
  localparam logic [3:0] OP_MUL_SENS  = 4'd5;
  localparam logic [3:0] OP_SENS      = 4'd6;
  localparam logic [3:0] OP_MUL_PLO   = 4'd7;
  localparam logic [3:0] OP_MUL_PHI   = 4'd8;
  localparam logic [3:0] OP_PROD      = 4'd9;
  localparam logic [3:0] OP_PRESS     = 4'd10;
  localparam logic [3:0] OP_ACC       = 4'd11;
  localparam logic [3:0] OP_AVG       = 4'd12;
  localparam logic [3:0] OP_OUT       = 4'd13;

  // Arithmetic constants of the calibration.
  localparam int TEMP_BASE   = 2000;
  localparam int TREF_SHIFT  = 8;
  localparam int TEMP_SHIFT  = 23;
  localparam int OFF_SHIFT   = 17;
  localparam int OFFTC_SHIFT = 6;
  localparam int SENS_SHIFT  = 16;
  localparam int SENSTC_SHIFT = 7;
  localparam int PROD_SHIFT  = 21;
  localparam int PRESS_SHIFT = 15;
  localparam int SENS_LO_W   = 17;

  localparam logic signed [31:0] P_MAX = 32'sd8388607;
  localparam logic signed [31:0] P_MIN = -32'sd8388608;

  typedef struct packed {
    logic block_end;
    logic div_done;
    logic out_full;
  } status_t;

endpackage

### sv/baro_div.sv
// Bit-serial signed divider: 32-bit dividend by an 8-bit unsigned divisor, truncating.
module baro_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic [7:0]         divisor,
  output logic               done,
  output logic signed [31:0] quotient
);

  logic        busy;
  logic        fin;
  logic        neg;
  logic [4:0]  step;
  logic [31:0] mag;
  logic [7:0]  rem;
  logic [7:0]  dvs;
  logic [8:0]  rem_sh;
  logic        fits;

  assign rem_sh = {rem, mag[31]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      step <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 5'd0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[31];
      mag <= dividend[31] ? 32'(-dividend) : 32'(dividend);
      rem <= 8'd0;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= 8'(rem_sh - {1'b0, dvs});
      end else begin
        rem <= rem_sh[7:0];
      end
      mag <= {mag[30:0], fits};
    end else if (fin) begin
      quotient <= neg ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

### sv/baro_dp.sv
// Datapath: configuration registers, shared multiplier, compensation, block sum and output register.
module baro_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic [3:0]          op,
  output baro_pkg::status_t   status,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [47:0]         in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [71:0]         out_data,
  output logic                out_flag
);

  // Configuration registers.
  logic [15:0] c1, c2, c3, c4, c5, c6;
  logic [7:0]  avg_count;
  logic [7:0]  cnt_eff;

  // Working registers.
  logic [23:0]        d1, d2;
  logic signed [24:0] dt;
  logic signed [24:0] ma, mb;
  logic signed [49:0] prod;
  logic signed [18:0] temp;
  logic signed [35:0] off;
  logic signed [34:0] sens;
  logic [40:0]        lo;
  logic signed [59:0] acc;
  logic signed [39:0] pdiff;
  logic signed [23:0] press;
  logic               avg_flag;

  // Averaging state.
  logic [7:0]         sample_counter;
  logic signed [31:0] pressure_sum;
  logic signed [23:0] held_average;
  logic signed [31:0] sum_next;
  logic [7:0]         cnt_next;
  logic               block_end;
  logic               div_start;
  logic               div_done;
  logic signed [31:0] quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= 16'd0;
      c2 <= 16'd0;
      c3 <= 16'd0;
      c4 <= 16'd0;
      c5 <= 16'd0;
      c6 <= 16'd0;
      avg_count <= 8'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        baro_pkg::REG_SENS:      c1 <= cfg_data;
        baro_pkg::REG_OFFSET:    c2 <= cfg_data;
        baro_pkg::REG_SENS_TC:   c3 <= cfg_data;
        baro_pkg::REG_OFFSET_TC: c4 <= cfg_data;
        baro_pkg::REG_TREF:      c5 <= cfg_data;
        baro_pkg::REG_TEMPSENS:  c6 <= cfg_data;
        baro_pkg::REG_AVG_COUNT: avg_count <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // A block size of zero behaves as one.
  assign cnt_eff = (avg_count == 8'd0) ? 8'd1 : avg_count;

  // Operand selection for the shared 25x25 signed multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (op)
      baro_pkg::OP_MUL_TEMP: begin
        ma = $signed({9'd0, c6});
        mb = dt;
      end
      baro_pkg::OP_MUL_OFF: begin
        ma = $signed({9'd0, c4});
        mb = dt;
      end
      baro_pkg::OP_MUL_SENS: begin
        ma = $signed({9'd0, c3});
        mb = dt;
      end
      baro_pkg::OP_MUL_PLO: begin
        ma = $signed({1'b0, d1});
        mb = $signed({8'd0, sens[baro_pkg::SENS_LO_W-1:0]});
      end
      baro_pkg::OP_MUL_PHI: begin
        ma = $signed({1'b0, d1});
        mb = $signed({{7{sens[34]}}, sens[34:baro_pkg::SENS_LO_W]});
      end
      default: ;
    endcase
  end

  assign pdiff    = 40'(acc >>> baro_pkg::PROD_SHIFT) - 40'(off);
  assign sum_next = pressure_sum + 32'(press);
  assign cnt_next = sample_counter + 8'd1;
  assign block_end = cnt_next >= cnt_eff;
  assign div_start = (op == baro_pkg::OP_ACC) && block_end;

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (op)
      baro_pkg::OP_LOAD: begin
        d1 <= in_data[23:0];
        d2 <= in_data[47:24];
      end
      baro_pkg::OP_DT:
        dt <= $signed({1'b0, d2}) - $signed({1'b0, c5, 8'd0});
      baro_pkg::OP_MUL_OFF:
        temp <= 19'(baro_pkg::TEMP_BASE + (prod >>> baro_pkg::TEMP_SHIFT));
      baro_pkg::OP_MUL_SENS:
        off <= 36'($signed({1'b0, c2, 17'd0}) + (prod >>> baro_pkg::OFFTC_SHIFT));
      baro_pkg::OP_SENS:
        sens <= 35'($signed({1'b0, c1, 16'd0}) + (prod >>> baro_pkg::SENSTC_SHIFT));
      baro_pkg::OP_MUL_PHI:
        lo <= prod[40:0];
      baro_pkg::OP_PROD:
        acc <= (60'(prod) <<< baro_pkg::SENS_LO_W) + 60'({1'b0, lo});
      baro_pkg::OP_PRESS:
        press <= 24'(pdiff >>> baro_pkg::PRESS_SHIFT);
      baro_pkg::OP_ACC:
        avg_flag <= block_end;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= 8'd0;
      pressure_sum   <= 32'sd0;
      held_average   <= 24'sd0;
    end else if (op == baro_pkg::OP_ACC) begin
      if (block_end) begin
        sample_counter <= 8'd0;
        pressure_sum   <= 32'sd0;
      end else begin
        sample_counter <= cnt_next;
        pressure_sum   <= sum_next;
      end
    end else if (op == baro_pkg::OP_AVG) begin
      if (quotient > baro_pkg::P_MAX) begin
        held_average <= 24'(baro_pkg::P_MAX);
      end else if (quotient < baro_pkg::P_MIN) begin
        held_average <= 24'(baro_pkg::P_MIN);
      end else begin
        held_average <= 24'(quotient);
      end
    end
  end

  baro_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (cnt_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  // Output register: holds one result word until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == baro_pkg::OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == baro_pkg::OP_OUT) begin
      out_data <= {5'd0, held_average, press, temp};
      out_flag <= avg_flag;
    end
  end

  assign status.block_end = block_end;
  assign status.div_done  = div_done;
  assign status.out_full  = out_valid;

endmodule

### sv/baro_ctrl.sv
// Controller: sequences one item through the datapath operations.
module baro_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  baro_pkg::status_t status,
  output logic [3:0]        op
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DT    = 4'd1;
  localparam logic [3:0] S_MTEMP = 4'd2;
  localparam logic [3:0] S_MOFF  = 4'd3;
  localparam logic [3:0] S_MSENS = 4'd4;
  localparam logic [3:0] S_SENS  = 4'd5;
  localparam logic [3:0] S_MPLO  = 4'd6;
  localparam logic [3:0] S_MPHI  = 4'd7;
  localparam logic [3:0] S_PROD  = 4'd8;
  localparam logic [3:0] S_PRESS = 4'd9;
  localparam logic [3:0] S_ACC   = 4'd10;
  localparam logic [3:0] S_DIVW  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    op = baro_pkg::OP_NOP;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op = baro_pkg::OP_LOAD;
          state_next = S_DT;
        end
      end
      S_DT: begin
        op = baro_pkg::OP_DT;
        state_next = S_MTEMP;
      end
      S_MTEMP: begin
        op = baro_pkg::OP_MUL_TEMP;
        state_next = S_MOFF;
      end
      S_MOFF: begin
        op = baro_pkg::OP_MUL_OFF;
        state_next = S_MSENS;
      end
      S_MSENS: begin
        op = baro_pkg::OP_MUL_SENS;
        state_next = S_SENS;
      end
      S_SENS: begin
        op = baro_pkg::OP_SENS;
        state_next = S_MPLO;
      end
      S_MPLO: begin
        op = baro_pkg::OP_MUL_PLO;
        state_next = S_MPHI;
      end
      S_MPHI: begin
        op = baro_pkg::OP_MUL_PHI;
        state_next = S_PROD;
      end
      S_PROD: begin
        op = baro_pkg::OP_PROD;
        state_next = S_PRESS;
      end
      S_PRESS: begin
        op = baro_pkg::OP_PRESS;
        state_next = S_ACC;
      end
      S_ACC: begin
        op = baro_pkg::OP_ACC;
        state_next = status.block_end ? S_DIVW : S_OUT;
      end
      S_DIVW: begin
        if (status.div_done) begin
          op = baro_pkg::OP_AVG;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!status.out_full) begin
          op = baro_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/baro_compensate_average.sv
// Top level of the barometer compensation and block averaging block.
//
// Each input word carries one raw pressure and one raw temperature conversion. The block
// applies the first-order calibration with the six coefficient registers, using exact signed
// arithmetic and arithmetic right shifts, and returns one output word per input word with the
// compensated temperature (0.01 degC), the compensated pressure (Pa), the latest block average
// of pressure and a flag in tuser that marks the word that completed a block. Items are
// handled one at a time: the work on each item includes a sequence of five products on one
// shared 25x25 multiplier (the 24x35 pressure product is split into two partial products).
// An item that completes a block also waits while the sum is divided by the block size in a
// bit-serial divider that resolves one quotient bit per cycle. The result sits in an output
// register, so the next word is accepted while the previous result still waits for the sink.
// The average is the truncated quotient, limited to the 24-bit range, and is held between
// blocks; a block size of zero counts as one.
// Configuration writes are always accepted and must only be issued while the block is idle.
module baro_compensate_average (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // raw_pressure [23:0], raw_temperature [47:24]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // temperature [18:0], pressure [42:19], average_pressure [66:43], zero fill [71:67]
  output logic [71:0] m_axis_tdata,
  // average_valid [0]
  output logic        m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  baro_pkg::status_t status;
  logic [3:0]        op;

  // Register writes are always accepted: cfg_ready is tied high.
  assign cfg_ready = 1'b1;

  baro_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .op       (op)
  );

  baro_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .status    (status),
    .cfg_write (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_flag  (m_axis_tuser)
  );

endmodule

### sv/baro_chk.sv
// Port-level checker for the barometer block and its bind statement.
module baro_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // No result word is offered right after reset.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result word offered after reset");

  // Items are processed one at a time, so input is closed right after an acceptance.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second word accepted while an item is in work");

  // A new result appears only after an item was in work, never straight from idle.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result word appeared without an item in work");

  // A stalled result word holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result word changed");

endmodule

bind baro_compensate_average baro_chk u_baro_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
